// ===== rtl/core/srpmt_pkg.sv =====
// shared types and constants for the signed radix parser with max tracker
`default_nettype none

package srpmt_pkg;

    localparam int MAG_W   = 63;
    localparam int RADIX_W = 6;
    localparam int TOP_W   = 7;
    localparam int DIGIT_W = 6;
    localparam int PROD_W  = MAG_W + RADIX_W;
    localparam int CFG_W   = 7;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [TOP_W-1:0]   TOP_RESET   = 7'd57;

    typedef enum logic {
        REG_RADIX     = 1'b0,
        REG_TOP_DIGIT = 1'b1
    } srpmt_reg_idx_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       word_last;
    } srpmt_in_t;

    typedef struct packed {
        logic             word_valid;
        logic             word_overflow;
        logic [MAG_W-1:0] word_magnitude;
        logic             word_negative;
        logic [MAG_W-1:0] best_magnitude_out;
        logic             best_negative_out;
        logic             any_valid_out;
    } srpmt_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_REPORT
    } srpmt_state_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic report;
    } srpmt_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } srpmt_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/signed_radix_parse_max_tracker_top.sv =====
// top level of the signed radix word parser with running maximum
`default_nettype none

// Parses words of characters (optional leading sign, leading zeros skipped,
// digits up to the configured top digit character) into a 63-bit magnitude in
// the configured base, flags overflow past 2^63-1, and reports one result per
// word together with the largest valid magnitude seen so far and its sign.
// For each character, the accept cycle registers the product of the
// accumulator and the radix, and the next cycle adds the digit and checks
// overflow. After the last character of a word, a report state updates the
// best-value tracker and loads the output register. The result waits in
// that register while the next word's characters are accepted; the report
// state holds only while an older result has not yet been taken.
// Configuration writes take effect the cycle after cfg_we and are meant for
// idle periods only.
module signed_radix_parse_max_tracker_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [srpmt_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire srpmt_pkg::srpmt_in_t        s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output srpmt_pkg::srpmt_out_t            m_data
);
    import srpmt_pkg::*;

    srpmt_cmd_t    cmd;
    srpmt_status_t status;

    srpmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srpmt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/srpmt_ctrl.sv =====
// controller state machine: sequences accept, accumulate and report
`default_nettype none

module srpmt_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire srpmt_pkg::srpmt_status_t status,
    output srpmt_pkg::srpmt_cmd_t       cmd
);
    import srpmt_pkg::*;

    srpmt_state_t state_reg;
    srpmt_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                state_next = status.last ? ST_REPORT : ST_IDLE;
            end
            ST_REPORT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.accum  = 1'b0;
        cmd.report = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_ACCUM: begin
                cmd.accum = 1'b1;
            end
            ST_REPORT: begin
                cmd.report = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // an accepted item always gets its accumulate cycle next
    a_load_then_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_ACCUM)
        else $error("accepted item not followed by accumulate");

    a_accum_single: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACCUM |=> state_reg != ST_ACCUM)
        else $error("accumulate lasted more than one cycle");

    // report only after a final character
    a_report_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACCUM && !status.last |=> state_reg == ST_IDLE)
        else $error("report entered without final character");

endmodule

`default_nettype wire

// ===== rtl/core/srpmt_datapath.sv =====
// datapath: config registers, word flags, radix multiply-accumulate, best tracker
`default_nettype none

module srpmt_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [srpmt_pkg::CFG_W-1:0] cfg_data,
    input  wire srpmt_pkg::srpmt_in_t      s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output srpmt_pkg::srpmt_out_t          m_data,
    input  wire srpmt_pkg::srpmt_cmd_t     cmd,
    output srpmt_pkg::srpmt_status_t       status
);
    import srpmt_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [TOP_W-1:0]   top_char_reg;

    logic [MAG_W-1:0]   acc_reg, acc_next;
    logic               at_start_reg, at_start_next;
    logic               lead_zero_reg, lead_zero_next;
    logic               saw_zero_reg, saw_zero_next;
    logic               saw_sig_reg, saw_sig_next;
    logic               word_ok_reg, word_ok_next;
    logic               minus_reg, minus_next;
    logic               ovf_reg, ovf_next;
    logic [MAG_W-1:0]   best_mag_reg, best_mag_next;
    logic               best_neg_reg, best_neg_next;
    logic               any_valid_reg, any_valid_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               take_reg, take_next;
    logic               last_reg, last_next;
    logic               m_valid_reg, m_valid_next;
    srpmt_out_t         m_data_reg, m_data_next;

    logic [RADIX_W-1:0] eff_radix;
    logic [7:0]         ch;
    logic [7:0]         top_char;
    logic [7:0]         digit_wide;
    logic               is_sign;
    logic               is_digit;
    logic [PROD_W:0]    sum;
    logic               wvalid;
    logic               wovf;
    logic               better;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= RADIX_RESET;
            top_char_reg <= TOP_RESET;
        end else if (cfg_we) begin
            case (srpmt_reg_idx_t'(cfg_index))
                REG_RADIX:     radix_reg    <= cfg_data[RADIX_W-1:0];
                REG_TOP_DIGIT: top_char_reg <= cfg_data[TOP_W-1:0];
                default:       radix_reg    <= radix_reg;
            endcase
        end
    end

    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = radix_reg;
        end
    end

    assign ch       = s_data.char_code;
    assign top_char = {1'b0, top_char_reg};
    assign is_sign  = at_start_reg && (ch == CHAR_MINUS || ch == CHAR_PLUS);

    // small bases take the whole '0'..top range, larger ones skip the gap after '9'
    always_comb begin
        if (eff_radix <= RADIX_W'(9)) begin
            is_digit = (ch >= CHAR_ZERO) && (ch <= top_char);
        end else begin
            is_digit = ((ch >= CHAR_ZERO) && (ch <= CHAR_NINE)) ||
                       ((ch >= CHAR_LOW_A) && (ch <= top_char));
        end
        digit_wide = (ch >= CHAR_LOW_A) ? (ch - CHAR_LOW_A + DIGIT_TEN) : (ch - CHAR_ZERO);
    end

    assign sum    = {1'b0, prod_reg} + (PROD_W + 1)'(digit_reg);
    assign wvalid = word_ok_reg && (saw_sig_reg || saw_zero_reg);
    assign wovf   = wvalid && ovf_reg;
    assign better = wvalid && !ovf_reg && (acc_reg > best_mag_reg);

    always_comb begin
        acc_next       = acc_reg;
        at_start_next  = at_start_reg;
        lead_zero_next = lead_zero_reg;
        saw_zero_next  = saw_zero_reg;
        saw_sig_next   = saw_sig_reg;
        word_ok_next   = word_ok_reg;
        minus_next     = minus_reg;
        ovf_next       = ovf_reg;
        best_mag_next  = best_mag_reg;
        best_neg_next  = best_neg_reg;
        any_valid_next = any_valid_reg;
        prod_next      = prod_reg;
        digit_next     = digit_reg;
        take_next      = take_reg;
        last_next      = last_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cmd.load) begin
            last_next     = s_data.word_last;
            take_next     = 1'b0;
            at_start_next = 1'b0;
            prod_next     = PROD_W'(acc_reg) * PROD_W'(eff_radix);
            digit_next    = digit_wide[DIGIT_W-1:0];
            if (is_sign) begin
                minus_next = (ch == CHAR_MINUS);
            end else if (lead_zero_reg && ch == CHAR_ZERO) begin
                saw_zero_next = 1'b1;
            end else begin
                lead_zero_next = 1'b0;
                if (!is_digit) begin
                    word_ok_next = 1'b0;
                end else begin
                    saw_sig_next = 1'b1;
                    take_next    = word_ok_reg && !ovf_reg;
                end
            end
        end

        if (cmd.accum) begin
            take_next = 1'b0;
            if (take_reg) begin
                if (sum > (PROD_W + 1)'(MAG_MAX)) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next = sum[MAG_W-1:0];
                end
            end
        end

        if (cmd.report) begin
            if (wvalid) begin
                any_valid_next = 1'b1;
            end
            if (better) begin
                best_mag_next = acc_reg;
                best_neg_next = minus_reg;
            end
            m_data_next.word_valid         = wvalid;
            m_data_next.word_overflow      = wovf;
            m_data_next.word_magnitude     = (wvalid && !ovf_reg) ? acc_reg : '0;
            m_data_next.word_negative      = minus_reg;
            m_data_next.best_magnitude_out = better ? acc_reg : best_mag_reg;
            m_data_next.best_negative_out  = better ? minus_reg : best_neg_reg;
            m_data_next.any_valid_out      = any_valid_reg || wvalid;
            m_valid_next                   = 1'b1;
            // start the next word fresh
            acc_next       = '0;
            at_start_next  = 1'b1;
            lead_zero_next = 1'b1;
            saw_zero_next  = 1'b0;
            saw_sig_next   = 1'b0;
            word_ok_next   = 1'b1;
            minus_next     = 1'b0;
            ovf_next       = 1'b0;
            last_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            at_start_reg  <= 1'b1;
            lead_zero_reg <= 1'b1;
            saw_zero_reg  <= 1'b0;
            saw_sig_reg   <= 1'b0;
            word_ok_reg   <= 1'b1;
            minus_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            best_mag_reg  <= '0;
            best_neg_reg  <= 1'b0;
            any_valid_reg <= 1'b0;
            take_reg      <= 1'b0;
            last_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            at_start_reg  <= at_start_next;
            lead_zero_reg <= lead_zero_next;
            saw_zero_reg  <= saw_zero_next;
            saw_sig_reg   <= saw_sig_next;
            word_ok_reg   <= word_ok_next;
            minus_reg     <= minus_next;
            ovf_reg       <= ovf_next;
            best_mag_reg  <= best_mag_next;
            best_neg_reg  <= best_neg_next;
            any_valid_reg <= any_valid_next;
            take_reg      <= take_next;
            last_reg      <= last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        digit_reg  <= digit_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.last     = last_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    // the running maximum never shrinks
    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> best_mag_reg >= $past(best_mag_reg))
        else $error("best magnitude decreased");

    // once a word overflowed the accumulator is frozen until the report
    a_ovf_freezes_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg && !cmd.report |=> $stable(acc_reg))
        else $error("accumulator changed after overflow");

    a_report_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |-> !m_valid_reg || m_ready)
        else $error("report overwrote a pending result");

endmodule

`default_nettype wire
